// ----- sv/cem_pkg.sv -----
// cem_pkg: shared widths, opcodes and status codes of the clock exchange matcher.
// No dependencies; compiled first.
package cem_pkg;

    localparam int unsigned SLOTS_DEFAULT = 8;

    localparam int unsigned OP_W     = 2;
    localparam int unsigned ID_W     = 32;
    localparam int unsigned STAMP_W  = 62;
    localparam int unsigned MID_W    = 63;
    localparam int unsigned OFFS_W   = 64;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned COUNT_W  = 4;

    // opcodes
    localparam logic [OP_W-1:0] OP_REGISTER = 2'd0;
    localparam logic [OP_W-1:0] OP_COMPLETE = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR    = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUP      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_MISMATCH = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ORDER    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_SAMPLE   = 3'd5;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN  = 3'd6;

endpackage

// ----- sv/cem_if.sv -----
// cem_if: request and response channel interfaces (valid/ready plus payload).
// Depends on cem_pkg for field widths.
interface cem_req_if;
    logic                            valid;
    logic                            ready;
    logic [cem_pkg::OP_W-1:0]        opcode;
    logic [cem_pkg::ID_W-1:0]        xchg_id;
    logic [cem_pkg::STAMP_W-1:0]     send_stamp;
    logic [cem_pkg::STAMP_W-1:0]     remote_receive_stamp;
    logic [cem_pkg::STAMP_W-1:0]     remote_transmit_stamp;
    logic [cem_pkg::STAMP_W-1:0]     local_receive_stamp;

    modport source (
        output valid, opcode, xchg_id, send_stamp,
        output remote_receive_stamp, remote_transmit_stamp, local_receive_stamp,
        input  ready
    );
    modport sink (
        input  valid, opcode, xchg_id, send_stamp,
        input  remote_receive_stamp, remote_transmit_stamp, local_receive_stamp,
        output ready
    );
endinterface

interface cem_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [cem_pkg::STATUS_W-1:0]    status_code;
    logic [cem_pkg::STAMP_W-1:0]     round_trip;
    logic signed [cem_pkg::OFFS_W-1:0] offset_doubled;
    logic [cem_pkg::MID_W-1:0]       local_mid_doubled;
    logic [cem_pkg::MID_W-1:0]       remote_mid_doubled;
    logic [cem_pkg::COUNT_W-1:0]     pending_count;

    modport source (
        output valid, status_code, round_trip, offset_doubled,
        output local_mid_doubled, remote_mid_doubled, pending_count,
        input  ready
    );
    modport sink (
        input  valid, status_code, round_trip, offset_doubled,
        input  local_mid_doubled, remote_mid_doubled, pending_count,
        output ready
    );
endinterface

// ----- sv/cem_ram.sv -----
// cem_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module cem_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 8,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/clock_exchange_matcher.sv -----
// clock_exchange_matcher: pending exchange table and four-stamp offset/delay unit.
// Depends on cem_pkg, cem_req_if / cem_rsp_if and cem_ram.
//
// Usage:
//   req channel carries one item: opcode, exchange id and four stamps t0..t3.
//   rsp channel returns exactly one item per request: status, round trip,
//   doubled offset, doubled local/remote midpoints and pending slot count.
//   Register (opcode 0) claims the lowest free slot; complete (opcode 1)
//   matches the id, checks t0 and computes the results; clear (opcode 2)
//   empties the table; opcode 3 answers unknown.
// Timing:
//   req.ready is high only in the idle state; one item at a time.
//   rsp.valid rises after accept via the result state for clear / unused
//   opcode; register and unknown id first scan the slots through the RAM read
//   port, one slot per cycle, with registered read data; a complete scans to
//   the matching slot, runs up to 6 steps in the shared 64-bit add/subtract
//   unit and then loads the response register.
// Reset: all slots inactive, count zero, no response pending. Ids and send
//   stamps live in RAM and are only read for active slots, so no sweep.
// Stall: the response sits in an output register; the block can take the
//   next request meanwhile and holds its finished result until rsp frees.
module clock_exchange_matcher #(
    parameter int unsigned SLOTS = cem_pkg::SLOTS_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    cem_req_if.sink   req,
    cem_rsp_if.source rsp
);

    localparam int unsigned IDXW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int unsigned CNTW  = $clog2(SLOTS + 1);
    localparam int unsigned ENTW  = cem_pkg::ID_W + cem_pkg::STAMP_W;
    localparam logic [IDXW-1:0] LAST_IDX = IDXW'(SLOTS - 1);

    // calc steps of the shared adder
    localparam logic [2:0] STEP_LSPAN = 3'd0;  // t3 - t0
    localparam logic [2:0] STEP_RSPAN = 3'd1;  // t2 - t1
    localparam logic [2:0] STEP_RTT   = 3'd2;  // local span - remote span
    localparam logic [2:0] STEP_LMID  = 3'd3;  // t0 + t3
    localparam logic [2:0] STEP_RMID  = 3'd4;  // t1 + t2
    localparam logic [2:0] STEP_OFFS  = 3'd5;  // rmid - lmid

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_CALC   = 4'b0100,
        S_RESULT = 4'b1000
    } state_t;

    // ---------------- control state ----------------
    state_t                      state_reg, state_next;
    logic [SLOTS-1:0]            active_reg, active_next;
    logic [CNTW-1:0]             total_reg, total_next;
    logic [IDXW-1:0]             scan_idx_reg, scan_idx_next;
    logic                        issue_done_reg, issue_done_next;
    logic                        cmp_vld_reg, cmp_vld_next;
    logic [IDXW-1:0]             cmp_idx_reg, cmp_idx_next;
    logic                        free_found_reg, free_found_next;
    logic [IDXW-1:0]             free_idx_reg, free_idx_next;
    logic [IDXW-1:0]             match_idx_reg, match_idx_next;
    logic [2:0]                  step_reg, step_next;
    logic                        out_valid_reg, out_valid_next;
    logic [cem_pkg::STATUS_W-1:0] status_reg, status_next;

    // ---------------- datapath registers ----------------
    logic [cem_pkg::OP_W-1:0]    op_reg;
    logic [cem_pkg::ID_W-1:0]    id_reg;
    logic [cem_pkg::STAMP_W-1:0] t0_reg, t1_reg, t2_reg, t3_reg;
    logic [cem_pkg::STAMP_W-1:0] span_l_reg, span_r_reg, rtt_reg;
    logic                        order_bad_reg;
    logic [cem_pkg::MID_W-1:0]   lmid_reg, rmid_reg;
    logic [cem_pkg::OFFS_W-1:0]  offs_reg;

    logic [cem_pkg::STATUS_W-1:0] out_status_reg;
    logic [cem_pkg::STAMP_W-1:0]  out_rtt_reg;
    logic [cem_pkg::OFFS_W-1:0]   out_offs_reg;
    logic [cem_pkg::MID_W-1:0]    out_lmid_reg, out_rmid_reg;
    logic [cem_pkg::COUNT_W-1:0]  out_count_reg;

    // ---------------- strobes ----------------
    logic req_take;
    logic out_load;
    logic vals_ok;

    // ---------------- slot RAM ----------------
    logic            ram_wr_en;
    logic [IDXW-1:0] ram_wr_addr;
    logic [ENTW-1:0] ram_rd_data;
    logic [cem_pkg::ID_W-1:0]    rd_ident;
    logic [cem_pkg::STAMP_W-1:0] rd_sent;
    logic            slot_hit;
    logic [IDXW-1:0] free_sel;

    // ---------------- shared adder ----------------
    logic [cem_pkg::OFFS_W-1:0] alu_a, alu_b;
    logic                       alu_sub;
    logic [cem_pkg::OFFS_W:0]   alu_sum;
    logic                       alu_borrow;

    cem_ram #(
        .WIDTH (ENTW),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data ({id_reg, t0_reg}),
        .rd_addr (scan_idx_reg),
        .rd_data (ram_rd_data)
    );

    assign rd_ident = ram_rd_data[ENTW-1 -: cem_pkg::ID_W];
    assign rd_sent  = ram_rd_data[cem_pkg::STAMP_W-1:0];
    assign slot_hit = active_reg[cmp_idx_reg] && (rd_ident == id_reg);
    assign free_sel = free_found_reg ? free_idx_reg : cmp_idx_reg;

    assign req.ready = (state_reg == S_IDLE);
    assign req_take  = req.valid && req.ready;

    // operand select per step; subtract via inverted operand and carry in
    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b1;
        case (step_reg)
            STEP_LSPAN:
            begin
                alu_a = 64'(t3_reg);
                alu_b = 64'(t0_reg);
            end
            STEP_RSPAN:
            begin
                alu_a = 64'(t2_reg);
                alu_b = 64'(t1_reg);
            end
            STEP_RTT:
            begin
                alu_a = 64'(span_l_reg);
                alu_b = 64'(span_r_reg);
            end
            STEP_LMID:
            begin
                alu_a   = 64'(t0_reg);
                alu_b   = 64'(t3_reg);
                alu_sub = 1'b0;
            end
            STEP_RMID:
            begin
                alu_a   = 64'(t1_reg);
                alu_b   = 64'(t2_reg);
                alu_sub = 1'b0;
            end
            STEP_OFFS:
            begin
                alu_a = 64'(rmid_reg);
                alu_b = 64'(lmid_reg);
            end
            default:
            begin
                alu_a = '0;
                alu_b = '0;
            end
        endcase
    end

    assign alu_sum    = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                        + 65'(alu_sub);
    assign alu_borrow = alu_sub && !alu_sum[cem_pkg::OFFS_W];

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next      = state_reg;
        active_next     = active_reg;
        total_next      = total_reg;
        scan_idx_next   = scan_idx_reg;
        issue_done_next = issue_done_reg;
        cmp_vld_next    = cmp_vld_reg;
        cmp_idx_next    = cmp_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        match_idx_next  = match_idx_reg;
        step_next       = step_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = free_sel;
        out_load        = 1'b0;

        if (rsp.valid && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_take)
                begin
                    scan_idx_next   = '0;
                    issue_done_next = 1'b0;
                    cmp_vld_next    = 1'b0;
                    free_found_next = 1'b0;
                    step_next       = STEP_LSPAN;
                    if (req.opcode == cem_pkg::OP_CLEAR)
                    begin
                        active_next = '0;
                        total_next  = '0;
                        status_next = cem_pkg::ST_OK;
                        state_next  = S_RESULT;
                    end
                    else if (req.opcode == cem_pkg::OP_REGISTER ||
                             req.opcode == cem_pkg::OP_COMPLETE)
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        status_next = cem_pkg::ST_UNKNOWN;
                        state_next  = S_RESULT;
                    end
                end
            end

            S_SCAN:
            begin
                // issue side: one RAM read per cycle
                if (!issue_done_reg)
                begin
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = scan_idx_reg;
                    if (scan_idx_reg == LAST_IDX)
                    begin
                        issue_done_next = 1'b1;
                    end
                    else
                    begin
                        scan_idx_next = scan_idx_reg + 1'b1;
                    end
                end
                else
                begin
                    cmp_vld_next = 1'b0;
                end

                // compare side: data for cmp_idx_reg arrives now
                if (cmp_vld_reg)
                begin
                    if (slot_hit)
                    begin
                        if (op_reg == cem_pkg::OP_REGISTER)
                        begin
                            status_next = cem_pkg::ST_DUP;
                            state_next  = S_RESULT;
                        end
                        else if (rd_sent != t0_reg)
                        begin
                            status_next = cem_pkg::ST_MISMATCH;
                            state_next  = S_RESULT;
                        end
                        else
                        begin
                            match_idx_next = cmp_idx_reg;
                            step_next      = STEP_LSPAN;
                            state_next     = S_CALC;
                        end
                    end
                    else
                    begin
                        if (!active_reg[cmp_idx_reg] && !free_found_reg)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next   = cmp_idx_reg;
                        end
                        if (cmp_idx_reg == LAST_IDX)
                        begin
                            state_next = S_RESULT;
                            if (op_reg == cem_pkg::OP_REGISTER)
                            begin
                                if (free_found_reg || !active_reg[cmp_idx_reg])
                                begin
                                    ram_wr_en             = 1'b1;
                                    active_next[free_sel] = 1'b1;
                                    total_next            = total_reg + 1'b1;
                                    status_next           = cem_pkg::ST_OK;
                                end
                                else
                                begin
                                    status_next = cem_pkg::ST_FULL;
                                end
                            end
                            else
                            begin
                                status_next = cem_pkg::ST_UNKNOWN;
                            end
                        end
                    end
                end
            end

            S_CALC:
            begin
                step_next = step_reg + 1'b1;
                case (step_reg)
                    STEP_RSPAN:
                    begin
                        if (alu_borrow || order_bad_reg)
                        begin
                            status_next = cem_pkg::ST_ORDER;
                            state_next  = S_RESULT;
                        end
                    end
                    STEP_RTT:
                    begin
                        if (alu_borrow)
                        begin
                            status_next = cem_pkg::ST_SAMPLE;
                            state_next  = S_RESULT;
                        end
                    end
                    STEP_OFFS:
                    begin
                        active_next[match_idx_reg] = 1'b0;
                        total_next  = total_reg - 1'b1;
                        status_next = cem_pkg::ST_OK;
                        state_next  = S_RESULT;
                    end
                    default:
                    begin
                        status_next = status_reg;
                    end
                endcase
            end

            S_RESULT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            active_reg     <= '0;
            total_reg      <= '0;
            scan_idx_reg   <= '0;
            issue_done_reg <= 1'b0;
            cmp_vld_reg    <= 1'b0;
            cmp_idx_reg    <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            match_idx_reg  <= '0;
            step_reg       <= STEP_LSPAN;
            status_reg     <= cem_pkg::ST_OK;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            active_reg     <= active_next;
            total_reg      <= total_next;
            scan_idx_reg   <= scan_idx_next;
            issue_done_reg <= issue_done_next;
            cmp_vld_reg    <= cmp_vld_next;
            cmp_idx_reg    <= cmp_idx_next;
            free_found_reg <= free_found_next;
            free_idx_reg   <= free_idx_next;
            match_idx_reg  <= match_idx_next;
            step_reg       <= step_next;
            status_reg     <= status_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // value fields are only meaningful on a successful complete
    assign vals_ok = (op_reg == cem_pkg::OP_COMPLETE) && (status_reg == cem_pkg::ST_OK);

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            op_reg <= req.opcode;
            id_reg <= req.xchg_id;
            t0_reg <= req.send_stamp;
            t1_reg <= req.remote_receive_stamp;
            t2_reg <= req.remote_transmit_stamp;
            t3_reg <= req.local_receive_stamp;
        end

        if (state_reg == S_CALC)
        begin
            case (step_reg)
                STEP_LSPAN:
                begin
                    span_l_reg    <= alu_sum[cem_pkg::STAMP_W-1:0];
                    order_bad_reg <= alu_borrow;
                end
                STEP_RSPAN: span_r_reg <= alu_sum[cem_pkg::STAMP_W-1:0];
                STEP_RTT:   rtt_reg    <= alu_sum[cem_pkg::STAMP_W-1:0];
                STEP_LMID:  lmid_reg   <= alu_sum[cem_pkg::MID_W-1:0];
                STEP_RMID:  rmid_reg   <= alu_sum[cem_pkg::MID_W-1:0];
                STEP_OFFS:  offs_reg   <= alu_sum[cem_pkg::OFFS_W-1:0];
                default:    offs_reg   <= offs_reg;
            endcase
        end

        if (out_load)
        begin
            out_status_reg <= status_reg;
            out_rtt_reg    <= vals_ok ? rtt_reg  : '0;
            out_offs_reg   <= vals_ok ? offs_reg : '0;
            out_lmid_reg   <= vals_ok ? lmid_reg : '0;
            out_rmid_reg   <= vals_ok ? rmid_reg : '0;
            out_count_reg  <= cem_pkg::COUNT_W'(total_reg);
        end
    end

    assign rsp.valid              = out_valid_reg;
    assign rsp.status_code        = out_status_reg;
    assign rsp.round_trip         = out_rtt_reg;
    assign rsp.offset_doubled     = out_offs_reg;
    assign rsp.local_mid_doubled  = out_lmid_reg;
    assign rsp.remote_mid_doubled = out_rmid_reg;
    assign rsp.pending_count      = out_count_reg;

endmodule
